### src/assert_macros.svh
// Assertion macros for the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons at the same edge at which ante holds.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons at the edge after the one at which ante holds.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/bemcc_pkg.sv
// Shared types and constants of the battery energy meter.
`timescale 1ns / 1ps

package bemcc_pkg;

	localparam int unsigned SAMPLE_W = 10;
	localparam int unsigned QUEUE_DEPTH = 4;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_CURRENT_OFFSET   = 3'd0;
	localparam logic [2:0] REG_CHARGER_MODE     = 3'd1;
	localparam logic [2:0] REG_CHARGE_ON_LEVEL  = 3'd2;
	localparam logic [2:0] REG_CHARGE_OFF_LEVEL = 3'd3;
	localparam logic [2:0] REG_FULL_CAPACITY    = 3'd4;

	// Charger modes
	localparam logic [1:0] MODE_FORCE_OFF = 2'd0;
	localparam logic [1:0] MODE_AUTO      = 2'd1;
	localparam logic [1:0] MODE_FORCE_ON  = 2'd2;

	// Report kinds
	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_POWER  = 2'd1;
	localparam logic [1:0] KIND_ENERGY = 2'd2;

	// Register reset values
	localparam logic [9:0]  OFFSET_RESET    = 10'd538;
	localparam logic [1:0]  MODE_RESET      = MODE_AUTO;
	localparam logic [9:0]  ON_LEVEL_RESET  = 10'd798;
	localparam logic [9:0]  OFF_LEVEL_RESET = 10'd897;
	localparam logic [30:0] CAPACITY_RESET  = 31'd302400;

	// Power sum units per joule and its reciprocal scaled by 2^RECIP_SHIFT
	localparam logic [31:0] JOULE_UNITS = 32'd1025641;
	localparam int unsigned RECIP_SHIFT = 51;
	localparam logic [63:0] RECIP_WIDE = (64'd1 << RECIP_SHIFT) / 64'd1025641;
	localparam logic [31:0] JOULE_RECIP = RECIP_WIDE[31:0];
	localparam int unsigned QUOT_W = 13;

	// Battery counter at or above this level reads as an underflow
	localparam logic [31:0] UNDERFLOW_LIMIT = 32'h7fff_ffff - 32'd42;

	typedef struct packed {
		logic [9:0]         voltage;
		logic signed [10:0] current;
		logic [8:0]         solar;
		logic signed [20:0] battery_product;
		logic [18:0]        solar_product;
		logic               tick;
	} bemcc_item_t;

	typedef struct packed {
		logic [1:0]  charger_mode;
		logic [9:0]  charge_on_level;
		logic [9:0]  charge_off_level;
		logic [30:0] full_capacity;
	} bemcc_cfg_t;

	typedef enum logic [2:0] {
		BK_RUN,
		BK_MUL,
		BK_REM,
		BK_FIX,
		BK_UPD
	} bemcc_back_state_t;

endpackage

### src/bemcc_front.sv
// Front part: accepts sample sets, removes offset, forms products, marks ticks.
`timescale 1ns / 1ps

module bemcc_front #(
	parameter int unsigned SAMPLES_PER_SECOND = 100
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [31:0]            in_data,
	input  logic [9:0]             current_offset,
	input  logic                   q_full,
	output logic                   in_ready,
	output logic                   push,
	output bemcc_pkg::bemcc_item_t item
);

	localparam int unsigned CNT_W = (SAMPLES_PER_SECOND > 1) ? $clog2(SAMPLES_PER_SECOND) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_SECOND - 1);

	logic [CNT_W-1:0]   count_q;
	logic [9:0]         voltage;
	logic [9:0]         current_raw;
	logic [9:0]         solar_raw;
	logic signed [10:0] current;
	logic signed [21:0] battery_full;
	logic [18:0]        solar_full;
	logic               tick;

	assign in_ready    = !q_full;
	assign push        = in_valid && in_ready;
	assign voltage     = in_data[9:0];
	assign current_raw = in_data[19:10];
	assign solar_raw   = in_data[29:20];
	assign current     = $signed({1'b0, current_raw}) - $signed({1'b0, current_offset});
	assign battery_full = $signed({1'b0, voltage}) * current;
	assign solar_full  = voltage * solar_raw[9:1];
	assign tick        = (count_q == CNT_LAST);

	always_comb begin
		item.voltage         = voltage;
		item.current         = current;
		item.solar           = solar_raw[9:1];
		item.battery_product = battery_full[20:0];
		item.solar_product   = solar_full;
		item.tick            = tick;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= tick ? '0 : count_q + CNT_W'(1);
		end
	end

endmodule

### src/bemcc_queue.sv
// Short queue between the front and the back part.
`timescale 1ns / 1ps

module bemcc_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  bemcc_pkg::bemcc_item_t wr_item,
	input  logic                   pop,
	output logic                   full,
	output logic                   valid,
	output bemcc_pkg::bemcc_item_t rd_item
);

	localparam int unsigned DEPTH = bemcc_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	bemcc_pkg::bemcc_item_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign rd_item = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### src/bemcc_back.sv
// Back part: power sums, joule conversion, charger control, result register.
`timescale 1ns / 1ps

module bemcc_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  bemcc_pkg::bemcc_item_t q_item,
	input  bemcc_pkg::bemcc_cfg_t  cfg,
	input  logic                   out_ready,
	output logic                   pop,
	output logic                   out_valid,
	output logic [95:0]            out_data,
	output logic [2:0]             out_user
);

	localparam int unsigned QW = bemcc_pkg::QUOT_W;

	bemcc_pkg::bemcc_back_state_t state_q, state_d;

	logic        load_run, load_upd, out_free;

	logic [31:0] bsum_q, ssum_q, sj_q;
	logic [30:0] bj_q;
	logic [1:0]  phase_q;
	logic        hyst_q, drive_q;

	logic [31:0] bsum_new, ssum_new, bmag_new;
	logic        neg_s1;
	logic [31:0] bmag_s1, smag_s1;
	bemcc_pkg::bemcc_item_t tick_item_s1;
	logic [63:0] bprod_wide, sprod_wide;
	logic [QW-1:0] bq_s2, sq_s2, bq_s3, sq_s3, bq_s4, sq_s4;
	logic [31:0] bmag_s2, smag_s2, brem_s3, srem_s3, brem_s4, srem_s4;
	logic        bfix, sfix;

	logic [QW-1:0] bq_upd, sq_upd;
	logic [31:0] bsum_upd, ssum_upd, bj_calc, sj_upd;
	logic [30:0] bj_upd;
	logic        hyst_upd, drive_upd;
	logic [1:0]  phase_inc, phase_upd, kind_upd;

	assign out_free = !out_valid || out_ready;

	// Accumulate the popped sample into the power sums
	assign bsum_new = bsum_q + {{11{q_item.battery_product[20]}}, q_item.battery_product};
	assign ssum_new = ssum_q + {13'd0, q_item.solar_product};
	assign bmag_new = bsum_new[31] ? (~bsum_new + 32'd1) : bsum_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bemcc_pkg::BK_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_run = 1'b0;
		load_upd = 1'b0;
		unique case (state_q)
			bemcc_pkg::BK_RUN: begin
				if (q_valid && q_item.tick) begin
					pop     = 1'b1;
					state_d = bemcc_pkg::BK_MUL;
				end else if (q_valid && out_free) begin
					pop      = 1'b1;
					load_run = 1'b1;
				end
			end
			bemcc_pkg::BK_MUL: state_d = bemcc_pkg::BK_REM;
			bemcc_pkg::BK_REM: state_d = bemcc_pkg::BK_FIX;
			bemcc_pkg::BK_FIX: state_d = bemcc_pkg::BK_UPD;
			bemcc_pkg::BK_UPD: begin
				if (out_free) begin
					load_upd = 1'b1;
					state_d  = bemcc_pkg::BK_RUN;
				end
			end
			default: state_d = bemcc_pkg::BK_RUN;
		endcase
	end

	// Reciprocal division: estimate, remainder, one correction step
	assign bprod_wide = bmag_s1 * bemcc_pkg::JOULE_RECIP;
	assign sprod_wide = smag_s1 * bemcc_pkg::JOULE_RECIP;
	assign bfix = (brem_s3 >= bemcc_pkg::JOULE_UNITS);
	assign sfix = (srem_s3 >= bemcc_pkg::JOULE_UNITS);

	always_ff @(posedge clk) begin
		if (pop && q_item.tick) begin
			neg_s1       <= bsum_new[31];
			bmag_s1      <= bmag_new;
			smag_s1      <= ssum_new;
			tick_item_s1 <= q_item;
		end
		if (state_q == bemcc_pkg::BK_MUL) begin
			bq_s2   <= bprod_wide[bemcc_pkg::RECIP_SHIFT +: QW];
			sq_s2   <= sprod_wide[bemcc_pkg::RECIP_SHIFT +: QW];
			bmag_s2 <= bmag_s1;
			smag_s2 <= smag_s1;
		end
		if (state_q == bemcc_pkg::BK_REM) begin
			bq_s3   <= bq_s2;
			sq_s3   <= sq_s2;
			brem_s3 <= bmag_s2 - 32'(bq_s2 * bemcc_pkg::JOULE_UNITS);
			srem_s3 <= smag_s2 - 32'(sq_s2 * bemcc_pkg::JOULE_UNITS);
		end
		if (state_q == bemcc_pkg::BK_FIX) begin
			bq_s4   <= bq_s3 + QW'(bfix);
			sq_s4   <= sq_s3 + QW'(sfix);
			brem_s4 <= bfix ? (brem_s3 - bemcc_pkg::JOULE_UNITS) : brem_s3;
			srem_s4 <= sfix ? (srem_s3 - bemcc_pkg::JOULE_UNITS) : srem_s3;
		end
	end

	// Tick update of counters, charger and report phase
	always_comb begin
		if (phase_q == 2'd0) begin
			bq_upd   = '0;
			sq_upd   = '0;
			bsum_upd = '0;
			ssum_upd = '0;
		end else begin
			bq_upd   = bq_s4;
			sq_upd   = sq_s4;
			bsum_upd = neg_s1 ? (~brem_s4 + 32'd1) : brem_s4;
			ssum_upd = srem_s4;
		end
		bj_calc = neg_s1 ? ({1'b0, bj_q} - 32'(bq_upd)) : ({1'b0, bj_q} + 32'(bq_upd));
		sj_upd  = sj_q + 32'(sq_upd);
		priority if (bj_calc >= bemcc_pkg::UNDERFLOW_LIMIT) begin
			bj_upd = '0;
		end else if (bj_calc > {1'b0, cfg.full_capacity}) begin
			bj_upd = cfg.full_capacity;
		end else begin
			bj_upd = bj_calc[30:0];
		end

		hyst_upd  = hyst_q;
		drive_upd = drive_q;
		if (cfg.charger_mode == bemcc_pkg::MODE_AUTO) begin
			if (!hyst_q && (tick_item_s1.voltage <= cfg.charge_on_level)) begin
				hyst_upd  = 1'b1;
				drive_upd = 1'b1;
			end else if (hyst_q && (tick_item_s1.voltage >= cfg.charge_off_level)) begin
				hyst_upd  = 1'b0;
				drive_upd = 1'b0;
			end
		end
		if (cfg.charger_mode == bemcc_pkg::MODE_FORCE_OFF) begin
			drive_upd = 1'b0;
		end else if (cfg.charger_mode == bemcc_pkg::MODE_FORCE_ON) begin
			drive_upd = 1'b1;
		end

		phase_inc = phase_q + 2'd1;
		if (!phase_inc[0]) begin
			kind_upd  = bemcc_pkg::KIND_ENERGY;
			phase_upd = 2'd2;
		end else begin
			kind_upd  = bemcc_pkg::KIND_POWER;
			phase_upd = phase_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsum_q  <= '0;
			ssum_q  <= '0;
			bj_q    <= bemcc_pkg::CAPACITY_RESET;
			sj_q    <= '0;
			phase_q <= '0;
			hyst_q  <= 1'b0;
			drive_q <= 1'b0;
		end else if (load_upd) begin
			bsum_q  <= bsum_upd;
			ssum_q  <= ssum_upd;
			bj_q    <= bj_upd;
			sj_q    <= sj_upd;
			phase_q <= phase_upd;
			hyst_q  <= hyst_upd;
			drive_q <= drive_upd;
		end else if (pop) begin
			bsum_q <= bsum_new;
			ssum_q <= ssum_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_run || load_upd) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_upd) begin
			out_data <= {2'b00, tick_item_s1.solar, tick_item_s1.current,
				tick_item_s1.voltage, sj_upd, bj_upd, drive_upd};
			out_user <= {kind_upd, 1'b1};
		end else if (load_run) begin
			out_data <= {2'b00, q_item.solar, q_item.current, q_item.voltage,
				sj_q, bj_q, drive_q};
			out_user <= {bemcc_pkg::KIND_NONE, 1'b0};
		end
	end

endmodule

### src/battery_energy_meter_charge_control.sv
// Top level of the battery energy meter with charger control.
`timescale 1ns / 1ps

// Battery energy meter with charge control. Each request on the slave stream
// carries one averaged sample set; each yields exactly one result request on
// the master stream, in order. The front part removes the current offset,
// halves the solar reading, forms both power products and marks every
// SAMPLES_PER_SECOND-th sample as a one-second tick; a four-entry queue hands
// the samples to the back part. Ordinary samples pass the back part at one per
// cycle while the master stream takes each result, through the queue entry and
// the output register. A tick sample holds the back part in the states MUL,
// REM, FIX and UPD: it runs the power sums through a reciprocal divider by
// 1025641 (multiply, remainder, one correction) and then updates the joule
// counters, the hysteresis charger control and the report phase. The queue
// soaks up part of each such pause, and once it has filled in a sustained
// stream the input holds off at every tick. Configuration writes take effect
// at once and are meant for idle periods only.
module battery_energy_meter_charge_control #(
	parameter int unsigned SAMPLES_PER_SECOND = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [30:0] cfg_data,
	// Sample input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [9:0] battery_voltage, [19:10] battery_current_raw, [29:20] solar_current_raw
	input  logic [31:0] s_axis_tdata,
	// Result output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] charger_on, [31:1] battery_energy, [63:32] solar_energy,
	// [73:64] voltage_now, [84:74] current_signed, [93:85] solar_scaled
	output logic [95:0] m_axis_tdata,
	// [0] second_done, [2:1] report_kind
	output logic [2:0]  m_axis_tuser
);

	logic [9:0]            current_offset_q;
	bemcc_pkg::bemcc_cfg_t cfg_q;

	logic                   push, pop, q_full, q_valid;
	bemcc_pkg::bemcc_item_t wr_item, rd_item;

	// Configuration registers; writes to unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_offset_q       <= bemcc_pkg::OFFSET_RESET;
			cfg_q.charger_mode     <= bemcc_pkg::MODE_RESET;
			cfg_q.charge_on_level  <= bemcc_pkg::ON_LEVEL_RESET;
			cfg_q.charge_off_level <= bemcc_pkg::OFF_LEVEL_RESET;
			cfg_q.full_capacity    <= bemcc_pkg::CAPACITY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bemcc_pkg::REG_CURRENT_OFFSET:   current_offset_q       <= cfg_data[9:0];
				bemcc_pkg::REG_CHARGER_MODE:     cfg_q.charger_mode     <= cfg_data[1:0];
				bemcc_pkg::REG_CHARGE_ON_LEVEL:  cfg_q.charge_on_level  <= cfg_data[9:0];
				bemcc_pkg::REG_CHARGE_OFF_LEVEL: cfg_q.charge_off_level <= cfg_data[9:0];
				bemcc_pkg::REG_FULL_CAPACITY:    cfg_q.full_capacity    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Accept and classify samples
	bemcc_front #(
		.SAMPLES_PER_SECOND(SAMPLES_PER_SECOND)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_data       (s_axis_tdata),
		.current_offset(current_offset_q),
		.q_full        (q_full),
		.in_ready      (s_axis_tready),
		.push          (push),
		.item          (wr_item)
	);

	// Decouple front and back so each can stall on its own
	bemcc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_item(wr_item),
		.pop    (pop),
		.full   (q_full),
		.valid  (q_valid),
		.rd_item(rd_item)
	);

	// Accumulate, convert to joules, drive charger, hold the result
	bemcc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (rd_item),
		.cfg      (cfg_q),
		.out_ready(m_axis_tready),
		.pop      (pop),
		.out_valid(m_axis_tvalid),
		.out_data (m_axis_tdata),
		.out_user (m_axis_tuser)
	);

endmodule

### src/bemcc_checker.sv
// Port-level checker for the battery energy meter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bemcc_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser
);

	`ASSERT_SAME(a_kind_legal, m_axis_tvalid, (m_axis_tuser[2:1] == bemcc_pkg::KIND_NONE) || (m_axis_tuser[2:1] == bemcc_pkg::KIND_POWER) || (m_axis_tuser[2:1] == bemcc_pkg::KIND_ENERGY), "illegal report kind")
	`ASSERT_SAME(a_kind_on_tick, m_axis_tvalid, m_axis_tuser[0] == (m_axis_tuser[2:1] != bemcc_pkg::KIND_NONE), "report kind does not match tick flag")
	`ASSERT_SAME(a_energy_bound, m_axis_tvalid, {1'b0, m_axis_tdata[31:1]} < bemcc_pkg::UNDERFLOW_LIMIT, "battery energy beyond underflow limit")
	`ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind battery_energy_meter_charge_control bemcc_port_checker u_bemcc_port_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

### test/bemcc_checker.sv
// Checker for the battery energy meter: predicts each result request and compares it.
`timescale 1ns / 1ps

module bemcc_checker #(
	parameter int unsigned SAMPLES_PER_SECOND = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [30:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [95:0] m_tdata,
	input  logic [2:0]  m_tuser,
	input  logic        drain,
	output int          fail_count,
	output int          results_seen
);

	localparam logic [1:0] PHASE_FIRST  = 2'd0;
	localparam logic [1:0] PHASE_STEADY = 2'd2;

	typedef struct packed {
		logic        charger_on;
		logic        second_done;
		logic [1:0]  report_kind;
		logic [30:0] battery_energy;
		logic [31:0] solar_energy;
		logic [9:0]  voltage_now;
		logic [10:0] current_signed;
		logic [8:0]  solar_scaled;
	} meter_reading_t;

	// Register copies
	logic [9:0]  offset_cfg;
	logic [1:0]  mode_cfg;
	logic [9:0]  on_cfg;
	logic [9:0]  off_cfg;
	logic [30:0] cap_cfg;

	// Meter state
	logic [6:0]  sample_count;
	logic [31:0] batt_sum;
	logic [31:0] solar_sum;
	logic [31:0] batt_joules;
	logic [31:0] solar_joules;
	logic [1:0]  phase;
	logic        charging;
	logic        drive;

	meter_reading_t pending_readings[$];
	bit drained;

	task automatic report_mismatch(input string what);
		$display("bemcc check: %s", what);
		fail_count++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("reading %0d %s is %h, expected %h",
				results_seen, name, got, want));
	endtask

	// Advance the meter by one sample set and return the reading it yields.
	task automatic meter_step(input logic [31:0] word, output meter_reading_t r);
		logic [9:0]         volts;
		logic signed [10:0] amps;
		logic [8:0]         sol;
		int                 volts_i;
		int                 amps_i;
		logic               neg;
		logic [31:0]        mag;
		logic [31:0]        bq;
		logic [31:0]        sq;
		volts = word[9:0];
		amps = $signed({1'b0, word[19:10]}) - $signed({1'b0, offset_cfg});
		sol = word[29:21];
		volts_i = int'(volts);
		amps_i = int'(amps);
		batt_sum = batt_sum + 32'(volts_i * amps_i);
		solar_sum = solar_sum + {22'd0, volts} * {23'd0, sol};
		r = '0;
		sample_count = sample_count + 7'd1;
		if (sample_count == 7'(SAMPLES_PER_SECOND)) begin
			sample_count = '0;
			neg = batt_sum[31];
			mag = neg ? -batt_sum : batt_sum;
			bq = mag / bemcc_pkg::JOULE_UNITS;
			sq = solar_sum / bemcc_pkg::JOULE_UNITS;
			// first tick only clears the sums
			if (phase == PHASE_FIRST) begin
				bq = '0;
				sq = '0;
				batt_sum = '0;
				solar_sum = '0;
			end
			if (neg) begin
				batt_sum = batt_sum + bq * bemcc_pkg::JOULE_UNITS;
				batt_joules = batt_joules - bq;
			end else begin
				batt_sum = batt_sum - bq * bemcc_pkg::JOULE_UNITS;
				batt_joules = batt_joules + bq;
			end
			solar_sum = solar_sum - sq * bemcc_pkg::JOULE_UNITS;
			solar_joules = solar_joules + sq;
			if (batt_joules >= bemcc_pkg::UNDERFLOW_LIMIT)
				batt_joules = '0;
			else if (batt_joules > {1'b0, cap_cfg})
				batt_joules = {1'b0, cap_cfg};
			if (!charging) begin
				if (volts <= on_cfg && mode_cfg == bemcc_pkg::MODE_AUTO) begin
					drive = 1'b1;
					charging = 1'b1;
				end
			end else if (volts >= off_cfg && mode_cfg == bemcc_pkg::MODE_AUTO) begin
				drive = 1'b0;
				charging = 1'b0;
			end
			if (mode_cfg == bemcc_pkg::MODE_FORCE_OFF)
				drive = 1'b0;
			else if (mode_cfg == bemcc_pkg::MODE_FORCE_ON)
				drive = 1'b1;
			phase = phase + 2'd1;
			r.second_done = 1'b1;
			if (!phase[0]) begin
				r.report_kind = bemcc_pkg::KIND_ENERGY;
				phase = PHASE_STEADY;
			end else begin
				r.report_kind = bemcc_pkg::KIND_POWER;
			end
		end else begin
			r.report_kind = bemcc_pkg::KIND_NONE;
		end
		r.charger_on = drive;
		r.battery_energy = batt_joules[30:0];
		r.solar_energy = solar_joules;
		r.voltage_now = volts;
		r.current_signed = amps;
		r.solar_scaled = sol;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		meter_reading_t want;
		meter_reading_t got;
		if (!arst_n) begin
			offset_cfg = bemcc_pkg::OFFSET_RESET;
			mode_cfg = bemcc_pkg::MODE_RESET;
			on_cfg = bemcc_pkg::ON_LEVEL_RESET;
			off_cfg = bemcc_pkg::OFF_LEVEL_RESET;
			cap_cfg = bemcc_pkg::CAPACITY_RESET;
			sample_count = '0;
			batt_sum = '0;
			solar_sum = '0;
			batt_joules = {1'b0, bemcc_pkg::CAPACITY_RESET};
			solar_joules = '0;
			phase = PHASE_FIRST;
			charging = 1'b0;
			drive = 1'b0;
			pending_readings.delete();
			drained = 1'b0;
			fail_count = 0;
			results_seen <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bemcc_pkg::REG_CURRENT_OFFSET:   offset_cfg = cfg_data[9:0];
					bemcc_pkg::REG_CHARGER_MODE:     mode_cfg = cfg_data[1:0];
					bemcc_pkg::REG_CHARGE_ON_LEVEL:  on_cfg = cfg_data[9:0];
					bemcc_pkg::REG_CHARGE_OFF_LEVEL: off_cfg = cfg_data[9:0];
					bemcc_pkg::REG_FULL_CAPACITY:    cap_cfg = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.charger_on = m_tdata[0];
				got.battery_energy = m_tdata[31:1];
				got.solar_energy = m_tdata[63:32];
				got.voltage_now = m_tdata[73:64];
				got.current_signed = m_tdata[84:74];
				got.solar_scaled = m_tdata[93:85];
				got.second_done = m_tuser[0];
				got.report_kind = m_tuser[2:1];
				if (pending_readings.size() == 0) begin
					report_mismatch($sformatf("reading %0d arrived with none expected",
						results_seen));
				end else begin
					want = pending_readings.pop_front();
					compare_field("charger_on", 32'(got.charger_on),
						32'(want.charger_on));
					compare_field("second_done", 32'(got.second_done),
						32'(want.second_done));
					compare_field("report_kind", 32'(got.report_kind),
						32'(want.report_kind));
					compare_field("battery_energy", 32'(got.battery_energy),
						32'(want.battery_energy));
					compare_field("solar_energy", got.solar_energy, want.solar_energy);
					compare_field("voltage_now", 32'(got.voltage_now),
						32'(want.voltage_now));
					compare_field("current_signed", 32'(got.current_signed),
						32'(want.current_signed));
					compare_field("solar_scaled", 32'(got.solar_scaled),
						32'(want.solar_scaled));
				end
				results_seen <= results_seen + 1;
			end
			if (s_tvalid && s_tready) begin
				meter_step(s_tdata, want);
				pending_readings.push_back(want);
			end
			if (drain && !drained) begin
				drained = 1'b1;
				if (pending_readings.size() != 0)
					report_mismatch($sformatf("%0d readings never arrived",
						pending_readings.size()));
			end
		end
	end

endmodule

### test/tb_battery_energy_meter_charge_control.sv
// Testbench top of the battery energy meter: stimulus, idling and the verdict.
`timescale 1ns / 1ps

module tb_battery_energy_meter_charge_control;

	localparam int unsigned SAMPLES = 100;
	// Scenarios 0..3 hit the special settings, the rest pick settings at random
	localparam int SCENARIOS = 12;
	localparam int SPECIAL_SCENARIOS = 4;
	localparam int DRAIN_CYCLES = 16;

	localparam logic [30:0] CAP_MAX = 31'd2147483604;
	localparam logic [9:0]  SAMPLE_MAX = 10'd1023;
	// Mode code the block does not define
	localparam logic [1:0]  MODE_UNDEFINED = 2'd3;
	// Register indexes past the last real register
	localparam logic [2:0]  REG_UNUSED_LO = 3'd5;
	localparam logic [2:0]  REG_UNUSED_HI = 3'd7;

	typedef struct {
		logic [9:0]  offset;
		logic [1:0]  mode;
		logic [9:0]  on_level;
		logic [9:0]  off_level;
		logic [30:0] capacity;
	} meter_settings_t;

	// Which way the battery current leans around the offset
	typedef enum int {
		TREND_DRAIN,
		TREND_CHARGE,
		TREND_MIXED
	} current_trend_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = bemcc_pkg::REG_CURRENT_OFFSET;
	logic [30:0] cfg_data = '0;
	logic        s_valid = 1'b0;
	logic [31:0] s_data = '0;
	logic        m_ready = 1'b0;
	logic        drain = 1'b0;
	wire         s_ready;
	wire         m_valid;
	wire  [95:0] m_data;
	wire  [2:0]  m_user;

	// Percent of cycles each side holds off
	int send_idle = 27;
	int recv_idle = 74;
	int items_sent = 0;
	int fail_count;
	int results_seen;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	battery_energy_meter_charge_control #(
		.SAMPLES_PER_SECOND(SAMPLES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_valid),
		.s_axis_tready(s_ready),
		.s_axis_tdata (s_data),
		.m_axis_tvalid(m_valid),
		.m_axis_tready(m_ready),
		.m_axis_tdata (m_data),
		.m_axis_tuser (m_user)
	);

	bemcc_checker #(
		.SAMPLES_PER_SECOND(SAMPLES)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_valid),
		.s_tready    (s_ready),
		.s_tdata     (s_data),
		.m_tvalid    (m_valid),
		.m_tready    (m_ready),
		.m_tdata     (m_data),
		.m_tuser     (m_user),
		.drain       (drain),
		.fail_count  (fail_count),
		.results_seen(results_seen)
	);

	// Stall the result side at random; recv_idle sets how often.
	always @(posedge clk)
		m_ready <= ($urandom_range(0, 99) >= recv_idle);

	// Hard stop well past the slowest correct run.
	initial begin
		#2_000_000;
		$display("battery_energy_meter_charge_control: mismatch");
		$finish;
	end

	// Pack voltage, battery current and solar current the way tdata carries them.
	function automatic logic [31:0] pack_sample(input logic [9:0] volts,
			input logic [9:0] amps, input logic [9:0] sol);
		return {2'b00, sol, amps, volts};
	endfunction

	// Draw one sample set. A quarter of the voltages sit within one of a charge level
	// so the hysteresis edges get hit on ticks; the current follows the trend.
	function automatic logic [31:0] random_sample(input meter_settings_t st,
			input current_trend_t trend);
		logic [9:0] volts;
		logic [9:0] amps;
		case ($urandom_range(0, 7))
			0: volts = 10'(st.on_level + $urandom_range(0, 2) - 1);
			1: volts = 10'(st.off_level + $urandom_range(0, 2) - 1);
			default: volts = 10'($urandom_range(0, SAMPLE_MAX));
		endcase
		case (trend)
			TREND_DRAIN:  amps = 10'($urandom_range(0, st.offset));
			TREND_CHARGE: amps = 10'($urandom_range(st.offset, SAMPLE_MAX));
			default:      amps = 10'($urandom_range(0, SAMPLE_MAX));
		endcase
		return pack_sample(volts, amps, 10'($urandom_range(0, SAMPLE_MAX)));
	endfunction

	// Offer one request, with a random hold-off first; return once it is taken.
	task automatic send_sample(input logic [31:0] word);
		while ($urandom_range(0, 99) < send_idle) begin
			s_valid <= 1'b0;
			@(posedge clk);
		end
		s_valid <= 1'b1;
		s_data <= word;
		@(posedge clk);
		while (!s_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Drop valid and hold until every request has its result back.
	task automatic settle();
		s_valid <= 1'b0;
		while (results_seen != items_sent)
			@(posedge clk);
	endtask

	// Write all five registers back to back, then one write to an unused index
	// that the block must ignore. Upper data bits of the narrow registers carry noise.
	task automatic apply_settings(input meter_settings_t st);
		logic [31:0] noise;
		noise = $urandom;
		cfg_we <= 1'b1;
		cfg_index <= bemcc_pkg::REG_CURRENT_OFFSET;
		cfg_data <= {noise[30:10], st.offset};
		@(posedge clk);
		cfg_index <= bemcc_pkg::REG_CHARGER_MODE;
		cfg_data <= {noise[30:2], st.mode};
		@(posedge clk);
		cfg_index <= bemcc_pkg::REG_CHARGE_ON_LEVEL;
		cfg_data <= {noise[29:9], st.on_level};
		@(posedge clk);
		cfg_index <= bemcc_pkg::REG_CHARGE_OFF_LEVEL;
		cfg_data <= {noise[28:8], st.off_level};
		@(posedge clk);
		cfg_index <= bemcc_pkg::REG_FULL_CAPACITY;
		cfg_data <= st.capacity;
		@(posedge clk);
		cfg_index <= 3'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI));
		cfg_data <= 31'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		meter_settings_t st;
		current_trend_t  trend;
		int              count;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset settings: all corners of the three fields,
		// alternating bit patterns, zero current, one step either side of the
		// offset, and voltages right on the reset charge levels.
		for (int k = 0; k < 8; k++)
			send_sample(pack_sample(k[0] ? SAMPLE_MAX : 10'd0,
				k[1] ? SAMPLE_MAX : 10'd0, k[2] ? SAMPLE_MAX : 10'd0));
		send_sample(pack_sample(10'h2aa, 10'h155, 10'h2aa));
		send_sample(pack_sample(10'h155, 10'h2aa, 10'h155));
		send_sample(pack_sample(bemcc_pkg::ON_LEVEL_RESET, bemcc_pkg::OFFSET_RESET, 10'd1));
		send_sample(pack_sample(bemcc_pkg::OFF_LEVEL_RESET,
			bemcc_pkg::OFFSET_RESET - 10'd1, 10'd2));
		send_sample(pack_sample(bemcc_pkg::OFF_LEVEL_RESET - 10'd1,
			bemcc_pkg::OFFSET_RESET + 10'd1, 10'd3));

		for (int sc = 0; sc < SCENARIOS; sc++) begin
			// Swap the idling sides a third of the way in, then stop idling.
			if (sc == SCENARIOS / 3) begin
				send_idle = 74;
				recv_idle = 27;
			end else if (sc == 2 * SCENARIOS / 3) begin
				send_idle = 0;
				recv_idle = 0;
			end
			st.offset = 10'($urandom_range(0, SAMPLE_MAX));
			st.on_level = 10'($urandom_range(0, SAMPLE_MAX));
			st.off_level = 10'($urandom_range(0, SAMPLE_MAX));
			count = (sc < SPECIAL_SCENARIOS) ? 200 : int'($urandom_range(100, 120));
			case (sc)
				0: begin
					// Widest hysteresis window inverted: toggle on every tick.
					// The large ceiling lets the counter climb past its reset value.
					st.offset = '0;
					st.mode = bemcc_pkg::MODE_AUTO;
					st.on_level = SAMPLE_MAX;
					st.off_level = '0;
					st.capacity = CAP_MAX;
					trend = TREND_CHARGE;
				end
				1: begin
					// Zero ceiling and pure discharge: clamp, then underflow.
					st.offset = SAMPLE_MAX;
					st.mode = bemcc_pkg::MODE_FORCE_OFF;
					st.on_level = '0;
					st.off_level = SAMPLE_MAX;
					st.capacity = '0;
					trend = TREND_DRAIN;
				end
				2: begin
					st.offset = '0;
					st.mode = bemcc_pkg::MODE_FORCE_ON;
					st.capacity = 31'd30;
					trend = TREND_CHARGE;
				end
				3: begin
					// Frozen charger while a small counter runs below zero.
					st.offset = SAMPLE_MAX;
					st.mode = MODE_UNDEFINED;
					st.capacity = 31'd30;
					trend = TREND_DRAIN;
				end
				default: begin
					st.mode = 2'($urandom_range(0, 3));
					case ($urandom_range(0, 3))
						0: st.capacity = 31'($urandom_range(0, 200));
						1: st.capacity = 31'($urandom_range(0, CAP_MAX));
						2: st.capacity = CAP_MAX;
						default: st.capacity = bemcc_pkg::CAPACITY_RESET;
					endcase
					trend = current_trend_t'($urandom_range(0, 2));
				end
			endcase
			settle();
			apply_settings(st);
			repeat (count)
				send_sample(random_sample(st, trend));
		end

		settle();
		// Give a stray extra result time to show up before the leftover check.
		repeat (DRAIN_CYCLES) @(posedge clk);
		drain <= 1'b1;
		repeat (2) @(posedge clk);
		if (fail_count == 0)
			$display("battery_energy_meter_charge_control: match");
		else
			$display("battery_energy_meter_charge_control: mismatch");
		$finish;
	end

endmodule
